// ===== rtl/mandelbrot_pixel_escape_defines.svh =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_PIXEL_ESCAPE_DEFINES_SVH
`define MANDELBROT_PIXEL_ESCAPE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define MPE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define MPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape package
// Fixed point widths, limits, register indexes and shared types.
// ----------------------------------------------------------------------------
package mpe_pkg;

  // Fixed point format: signed, FRAC_BITS fraction bits
  localparam int FRAC_BITS = 28;
  localparam int Z_W       = FRAC_BITS + 5;       // holds +-8.0
  localparam int MAG_W     = FRAC_BITS + 4;       // magnitude up to 8.0
  localparam int PROD_W    = 2 * MAG_W;
  localparam int SQ_W      = PROD_W - FRAC_BITS;  // square after shift
  localparam int CRS_W     = SQ_W + 1;            // doubled cross term
  localparam int R2_W      = SQ_W + 1;
  localparam int ACC_W     = SQ_W + 8;            // sums before saturation

  localparam int PIX_W     = 12;
  localparam int STEP_W    = 29;
  localparam int ORG_W     = 31;
  localparam int ITER_W    = 16;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  localparam int GREEN_W   = 6;
  localparam int BLUE_W    = 8;
  localparam int MOD_W     = 5;
  localparam logic [MOD_W-1:0] COLOR_MOD  = MOD_W'(25);
  localparam logic [MOD_W-1:0] MOD_TOP    = MOD_W'(24);
  localparam logic [BLUE_W-1:0] BLUE_MULT = BLUE_W'(6);

  localparam logic signed [ACC_W-1:0] LIM_ACC     = ACC_W'(64'sd8 <<< FRAC_BITS);
  localparam logic signed [ACC_W-1:0] NEG_LIM_ACC = -LIM_ACC;
  localparam logic [R2_W-1:0]         FOUR_R2     = R2_W'(64'd4 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER   = 3'd0,
    REG_C_STEP_X   = 3'd1,
    REG_C_ORIGIN_X = 3'd2,
    REG_C_STEP_Y   = 3'd3,
    REG_C_ORIGIN_Y = 3'd4
  } mpe_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } mpe_state_t;

  // Pixel to plane mapping registers
  typedef struct packed {
    logic        [STEP_W-1:0] step_x;
    logic signed [ORG_W-1:0]  origin_x;
    logic        [STEP_W-1:0] step_y;
    logic signed [ORG_W-1:0]  origin_y;
  } mpe_map_t;

  // One point c waiting for iteration
  typedef struct packed {
    logic signed [Z_W-1:0] cx;
    logic signed [Z_W-1:0] cy;
  } mpe_point_t;

  // Clamp a wide sum to +-8.0
  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    if (v > LIM_ACC) begin
      c = LIM_ACC;
    end else if (v < NEG_LIM_ACC) begin
      c = NEG_LIM_ACC;
    end else begin
      c = v;
    end
    return c[Z_W-1:0];
  endfunction

  // Magnitude of a clamped coordinate
  function automatic logic [MAG_W-1:0] mag_z(input logic signed [Z_W-1:0] z);
    logic [Z_W-1:0] n;
    n = z[Z_W-1] ? -z : z;
    return n[MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/mandelbrot_pixel_escape.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape engine
// Map a pixel to c, iterate z = z^2 + c and return count, flag and color.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Payload
//   --------  ------------------  -----------------------------------------
//   config    cfg_we              cfg_index, cfg_data
//   request   start / busy        pixel_x, pixel_y
//   result    done (one cycle)    green_level, blue_level, escaped,
//                                 iteration_count
//
// A request is taken at a clock edge with start high and busy low. The front
// end maps it to c, registers it and parks it in a short point queue, so new
// requests keep coming while the iteration unit works, until both the queue
// and the holding register are full. The iteration unit runs one step of
// z = z^2 + c per cycle through three 32 x 32 multipliers and finishes one
// point before it loads the next from the queue. That loop sets the
// sustained rate.
// rst is synchronous and active high; it empties the queue and idles the unit.
// Results cannot be stalled: done marks each one for exactly one cycle.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [mpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpe_pkg::CFG_W-1:0]     cfg_data,
  // pixel requests
  input  logic                          start,
  output logic                          busy,
  input  logic [mpe_pkg::PIX_W-1:0]     pixel_x,
  input  logic [mpe_pkg::PIX_W-1:0]     pixel_y,
  // results
  output logic                          done,
  output logic [mpe_pkg::GREEN_W-1:0]   green_level,
  output logic [mpe_pkg::BLUE_W-1:0]    blue_level,
  output logic                          escaped,
  output logic [mpe_pkg::ITER_W-1:0]    iteration_count
);
  import mpe_pkg::*;

  logic [ITER_W-1:0] iter_limit;
  mpe_map_t          map;

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  mpe_point_t        q_in;
  mpe_point_t        q_out;

  // Register file: unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit   <= ITER_W'(256);
      map.step_x   <= STEP_W'(1610613);
      map.origin_x <= -31'sd590558003;
      map.step_y   <= STEP_W'(1610613);
      map.origin_y <= -31'sd402653184;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_ITER:   iter_limit   <= cfg_data[ITER_W-1:0];
        REG_C_STEP_X:   map.step_x   <= cfg_data[STEP_W-1:0];
        REG_C_ORIGIN_X: map.origin_x <= signed'(cfg_data[ORG_W-1:0]);
        REG_C_STEP_Y:   map.step_y   <= cfg_data[STEP_W-1:0];
        REG_C_ORIGIN_Y: map.origin_y <= signed'(cfg_data[ORG_W-1:0]);
        default: begin
          iter_limit <= iter_limit;
        end
      endcase
    end
  end

  // Front end: take the request and compute c
  mpe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .map     (map),
    .q_full  (q_full),
    .busy    (busy),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  // Decouple the two sides
  mpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: iterate and color
  mpe_iter u_iter (
    .clk             (clk),
    .rst             (rst),
    .iter_limit      (iter_limit),
    .q_empty         (q_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .done            (done),
    .green_level     (green_level),
    .blue_level      (blue_level),
    .escaped         (escaped),
    .iteration_count (iteration_count)
  );

endmodule

// ===== rtl/mpe_front.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape front end
// Take a pixel request, map it to the point c and hand it to the queue.
// ----------------------------------------------------------------------------
module mpe_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mpe_pkg::PIX_W-1:0] pixel_x,
  input  logic [mpe_pkg::PIX_W-1:0] pixel_y,
  input  mpe_pkg::mpe_map_t         map,
  input  logic                      q_full,
  output logic                      busy,
  output logic                      q_push,
  output mpe_pkg::mpe_point_t       q_data
);
  import mpe_pkg::*;

  localparam int P_W = PIX_W + STEP_W;

  logic                    hold_valid;
  mpe_point_t              hold_point;
  logic                    take;
  logic [P_W-1:0]          prod_x;
  logic [P_W-1:0]          prod_y;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;

  assign q_push = hold_valid && !q_full;
  assign busy   = hold_valid && q_full;
  assign take   = start && !busy;
  assign q_data = hold_point;

  always_comb begin
    prod_x = P_W'(pixel_x) * P_W'(map.step_x);
    prod_y = P_W'(pixel_y) * P_W'(map.step_y);
    acc_x  = signed'(ACC_W'(prod_x)) + ACC_W'(map.origin_x);
    acc_y  = signed'(ACC_W'(prod_y)) + ACC_W'(map.origin_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_point.cx <= sat_z(acc_x);
      hold_point.cy <= sat_z(acc_y);
    end
  end

endmodule

// ===== rtl/mpe_queue.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape point queue
// Short first-in first-out store of mapped points between front and back.
// ----------------------------------------------------------------------------
`include "mandelbrot_pixel_escape_defines.svh"

module mpe_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mpe_pkg::mpe_point_t push_data,
  input  logic                pop,
  output mpe_pkg::mpe_point_t pop_data,
  output logic                full,
  output logic                empty
);
  import mpe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mpe_point_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `MPE_ASSERT(a_no_push_when_full, push, !full, "queue push while full")
  `MPE_ASSERT(a_no_pop_when_empty, pop, !empty, "queue pop while empty")

endmodule

// ===== rtl/mpe_iter.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape iteration unit
// Iterate z = z^2 + c one step per cycle and form the colored result.
// ----------------------------------------------------------------------------
`include "mandelbrot_pixel_escape_defines.svh"

module mpe_iter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mpe_pkg::ITER_W-1:0]  iter_limit,
  input  logic                        q_empty,
  input  mpe_pkg::mpe_point_t         q_data,
  output logic                        q_pop,
  output logic                        done,
  output logic [mpe_pkg::GREEN_W-1:0] green_level,
  output logic [mpe_pkg::BLUE_W-1:0]  blue_level,
  output logic                        escaped,
  output logic [mpe_pkg::ITER_W-1:0]  iteration_count
);
  import mpe_pkg::*;

  mpe_state_t              state;
  mpe_state_t              state_next;
  logic signed [Z_W-1:0]   zx;
  logic signed [Z_W-1:0]   zy;
  mpe_point_t              c;
  logic [ITER_W-1:0]       k;
  logic [MOD_W-1:0]        k_mod;

  logic [MAG_W-1:0]        mx;
  logic [MAG_W-1:0]        my;
  logic [PROD_W-1:0]       pxx;
  logic [PROD_W-1:0]       pyy;
  logic [PROD_W-1:0]       pxy;
  logic [SQ_W-1:0]         sqx;
  logic [SQ_W-1:0]         sqy;
  logic [CRS_W-1:0]        crs;
  logic [R2_W-1:0]         r2;
  logic signed [ACC_W-1:0] crs_s;
  logic signed [ACC_W-1:0] nx_acc;
  logic signed [ACC_W-1:0] ny_acc;

  logic                    hit;
  logic                    at_limit;
  logic                    load;
  logic                    advance;
  logic                    finish;

  logic [MOD_W-1:0]        it_mod;
  logic [GREEN_W-1:0]      green_val;
  logic [MOD_W:0]          dbl;
  logic [MOD_W-1:0]        dbl_mod;
  logic [BLUE_W-1:0]       blue_val;

  // Squares of the current z serve both the escape test of the previous
  // step and the next step
  always_comb begin
    mx     = mag_z(zx);
    my     = mag_z(zy);
    pxx    = PROD_W'(mx) * PROD_W'(mx);
    pyy    = PROD_W'(my) * PROD_W'(my);
    pxy    = PROD_W'(mx) * PROD_W'(my);
    sqx    = pxx[PROD_W-1:FRAC_BITS];
    sqy    = pyy[PROD_W-1:FRAC_BITS];
    crs    = pxy[PROD_W-1:FRAC_BITS-1];
    r2     = R2_W'(sqx) + R2_W'(sqy);
    crs_s  = (zx[Z_W-1] ^ zy[Z_W-1]) ? -signed'(ACC_W'(crs)) : signed'(ACC_W'(crs));
    nx_acc = signed'(ACC_W'(sqx)) - signed'(ACC_W'(sqy)) + ACC_W'(c.cx);
    ny_acc = crs_s + ACC_W'(c.cy);
  end

  assign hit      = (k != '0) && (r2 > FOUR_R2);
  assign at_limit = (k == iter_limit);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (hit || at_limit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    load    = 1'b0;
    advance = 1'b0;
    finish  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        load = !q_empty;
      end
      ST_RUN: begin
        finish  = hit || at_limit;
        advance = !(hit || at_limit);
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign q_pop = load;

  // Colors from the escaping index modulo 25
  always_comb begin
    it_mod    = (k_mod == '0) ? MOD_TOP : k_mod - 1'b1;
    green_val = {it_mod, 1'b0};
    dbl       = {it_mod, 1'b0};
    dbl_mod   = (dbl >= (MOD_W+1)'(COLOR_MOD)) ? MOD_W'(dbl - (MOD_W+1)'(COLOR_MOD))
                                               : dbl[MOD_W-1:0];
    blue_val  = BLUE_W'(dbl_mod) * BLUE_MULT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      c     <= q_data;
      zx    <= '0;
      zy    <= '0;
      k     <= '0;
      k_mod <= '0;
    end else if (advance) begin
      zx    <= sat_z(nx_acc);
      zy    <= sat_z(ny_acc);
      k     <= k + 1'b1;
      k_mod <= (k_mod == MOD_TOP) ? '0 : k_mod + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      escaped <= hit;
      if (hit) begin
        iteration_count <= k - 1'b1;
        green_level     <= green_val;
        blue_level      <= blue_val;
      end else begin
        iteration_count <= iter_limit;
        green_level     <= '0;
        blue_level      <= '0;
      end
    end
  end

  `MPE_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")
  `MPE_ASSERT(a_escape_below_limit, done && escaped, iteration_count < iter_limit,
    "escaped index not below limit")
  `MPE_ASSERT(a_inside_black, done && !escaped,
    (green_level == '0) && (blue_level == '0) && (iteration_count == iter_limit),
    "inside pixel not black at limit")

endmodule

// ===== verif/mandelbrot_pixel_escape_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape testbench
// Sends pixel requests through the start/busy port and computes the escape
// count, flag and color of each one in an independent fixed point model.
// Every done pulse is checked field by field against the oldest request
// still waiting for its result.
// The run moves from directed corners to many random views. The views
// include zoomed windows near the set boundary and fully random register
// values, with sender gaps of varying density.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape_tb;
  import mpe_pkg::*;

  // Cycles without any accepted request or result before the run is abandoned.
  // The slowest legal request has limit 65535 and never escapes.
  localparam int WATCHDOG_LIMIT  = 300000;
  localparam int REPORT_LIMIT    = 50;
  localparam int VIEWS_PER_PHASE = 6;
  localparam int PIXELS_PER_VIEW = 84;
  localparam int IDLE_PCT[3]     = '{0, 74, 24};

  // Plane limits in Q4.28: components clamp to +-8, escape when |z|^2 > 4
  localparam longint PLANE_LIM = longint'(8) <<< FRAC_BITS;
  localparam longint ESCAPE_R2 = longint'(4) <<< FRAC_BITS;
  localparam logic [127:0] PROD_CAP = 128'd1 << 62;

  // Palette: green = (count*2) mod 50, blue = (count*12) mod 150
  localparam int GREEN_MUL  = 2;
  localparam int GREEN_SPAN = 50;
  localparam int BLUE_MUL   = 12;
  localparam int BLUE_SPAN  = 150;

  typedef struct {
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic [GREEN_W-1:0] green;
    logic [BLUE_W-1:0]  blue;
    logic               esc;
    logic [ITER_W-1:0]  count;
  } pixel_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 start;
  logic                 busy;
  logic [PIX_W-1:0]     pixel_x;
  logic [PIX_W-1:0]     pixel_y;
  logic                 done;
  logic [GREEN_W-1:0]   green_level;
  logic [BLUE_W-1:0]    blue_level;
  logic                 escaped;
  logic [ITER_W-1:0]    iteration_count;

  // Local copy of the mapping registers, updated on every write to a known index
  logic [ITER_W-1:0]       view_iter_limit;
  logic [STEP_W-1:0]       view_step_x;
  logic signed [ORG_W-1:0] view_origin_x;
  logic [STEP_W-1:0]       view_step_y;
  logic signed [ORG_W-1:0] view_origin_y;

  // Results owed by the block, oldest request first
  pixel_result_t expected_pixels[$];

  int mismatches   = 0;
  int stall_cycles = 0;
  int req_gap_pct  = 0;
  int view_w       = 1 << PIX_W;
  int view_h       = 1 << PIX_W;

  mandelbrot_pixel_escape dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .done            (done),
    .green_level     (green_level),
    .blue_level      (blue_level),
    .escaped         (escaped),
    .iteration_count (iteration_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Escape time model
  // --------------------------------------------------------------------------

  function automatic longint clamp_plane(input longint v);
    if (v > PLANE_LIM) return PLANE_LIM;
    if (v < -PLANE_LIM) return -PLANE_LIM;
    return v;
  endfunction

  // Exact product of magnitudes, shifted, truncated toward zero, capped, then signed
  function automatic longint fixed_mul(input longint a, input longint b, input int sh);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] mag;
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    mag = ({64'd0, ma} * {64'd0, mb}) >> sh;
    if (mag > PROD_CAP) mag = PROD_CAP;
    return ((a < 0) != (b < 0)) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic pixel_result_t predict_escape(input logic [PIX_W-1:0] px,
                                                   input logic [PIX_W-1:0] py);
    pixel_result_t r;
    longint        cx, cy, zx, zy, nx, ny, r2;
    int            n, lim;
    bit            out_of_set;
    // The 12 bit index is used as it is, with no wrap
    cx = clamp_plane(longint'(view_origin_x) + longint'(px) * longint'(view_step_x));
    cy = clamp_plane(longint'(view_origin_y) + longint'(py) * longint'(view_step_y));
    zx = 0;
    zy = 0;
    n  = 0;
    lim = int'(view_iter_limit);
    out_of_set = 1'b0;
    while (!out_of_set && n < lim) begin
      nx = clamp_plane(fixed_mul(zx, zx, FRAC_BITS) - fixed_mul(zy, zy, FRAC_BITS) + cx);
      ny = clamp_plane(fixed_mul(zx, zy, FRAC_BITS - 1) + cy);
      zx = nx;
      zy = ny;
      r2 = fixed_mul(zx, zx, FRAC_BITS) + fixed_mul(zy, zy, FRAC_BITS);
      if (r2 > ESCAPE_R2) out_of_set = 1'b1;
      else n++;
    end
    r.px    = px;
    r.py    = py;
    r.esc   = out_of_set;
    r.count = ITER_W'(n);
    r.green = out_of_set ? GREEN_W'((n * GREEN_MUL) % GREEN_SPAN) : '0;
    r.blue  = out_of_set ? BLUE_W'((n * BLUE_MUL) % BLUE_SPAN) : '0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and watchdog
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int exp,
                               input pixel_result_t want);
    if (got != exp) begin
      report_mismatch($sformatf("pixel (%0d,%0d) %s got %0d expected %0d",
                                want.px, want.py, name, got, exp));
    end
  endtask

  // Check results before queueing the request taken at the same edge, so the
  // oldest expectation is always the one a done pulse belongs to.
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done === 1'b1) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result with count %0d and no request waiting",
                                    iteration_count));
        end else begin
          want = expected_pixels.pop_front();
          compare_field("green_level", green_level, want.green, want);
          compare_field("blue_level", blue_level, want.blue, want);
          compare_field("escaped", escaped, want.esc, want);
          compare_field("iteration_count", iteration_count, want.count, want);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_pixels.push_back(predict_escape(pixel_x, pixel_y));
      end
      stall_cycles <= (done === 1'b1 || (start === 1'b1 && busy === 1'b0)) ?
                      0 : stall_cycles + 1;
    end
  end

  // Abandon the run if neither side makes progress for too long
  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("[%0t] watchdog: no request or result for %0d cycles", $time, stall_cycles);
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Write one register; unknown indexes leave the local copy untouched
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MAX_ITER:   view_iter_limit = data[ITER_W-1:0];
      REG_C_STEP_X:   view_step_x     = data[STEP_W-1:0];
      REG_C_ORIGIN_X: view_origin_x   = data[ORG_W-1:0];
      REG_C_STEP_Y:   view_step_y     = data[STEP_W-1:0];
      REG_C_ORIGIN_Y: view_origin_y   = data[ORG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_view(input logic [CFG_W-1:0] lim, input logic [CFG_W-1:0] sx,
                            input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] sy,
                            input logic [CFG_W-1:0] oy);
    write_reg(REG_MAX_ITER, lim);
    write_reg(REG_C_STEP_X, sx);
    write_reg(REG_C_ORIGIN_X, ox);
    write_reg(REG_C_STEP_Y, sy);
    write_reg(REG_C_ORIGIN_Y, oy);
  endtask

  // Offer one request, with random gaps ahead of it, and hold it until taken.
  // start stays high between back-to-back requests.
  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    @(negedge clk);
    while ($urandom_range(99) < req_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Drop start and wait until every owed result has come back
  task automatic wait_results_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly inside the current view, sometimes anywhere in the 12 bit range
  function automatic logic [PIX_W-1:0] pick_coord(input int span);
    if ($urandom_range(9) == 0) return PIX_W'($urandom);
    return PIX_W'($urandom_range(0, span - 1));
  endfunction

  // Pick a new limit and window. Most windows are zoomed views around points
  // near the set, where escape counts vary widely. The rest are raw register
  // values that push c into saturation.
  task automatic load_random_view();
    logic [ITER_W-1:0] lim;
    logic [CFG_W-1:0]  junk;
    longint            span, step, mid_x, mid_y;
    junk = CFG_W'($urandom);
    if ($urandom_range(9) == 0) lim = ITER_W'($urandom_range(0, 8));
    else lim = ITER_W'($urandom_range(16, 320));
    if ($urandom_range(4) != 0) begin
      view_w = $urandom_range(16, 640);
      view_h = $urandom_range(16, 480);
      span   = (longint'(3) <<< FRAC_BITS) >>> $urandom_range(0, 12);
      step   = span / view_w;
      mid_x  = longint'($urandom_range(0, 5 << 27)) - (longint'(2) <<< FRAC_BITS);
      mid_y  = longint'($urandom_range(0, 644245094)) - 322122547;
      // Upper data bits beyond each register's width must be ignored
      write_view({junk[CFG_W-1:ITER_W], lim},
                 {junk[CFG_W-1:STEP_W], STEP_W'(step)},
                 CFG_W'(mid_x - span / 2),
                 {junk[CFG_W-1:STEP_W], STEP_W'(step)},
                 CFG_W'(mid_y - step * view_h / 2));
    end else begin
      view_w = 1 << PIX_W;
      view_h = 1 << PIX_W;
      write_view({junk[CFG_W-1:ITER_W], lim}, CFG_W'($urandom), CFG_W'($urandom),
                 CFG_W'($urandom), CFG_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset view: pixel (0,0) maps to c = -2.2 - 1.5i, the other corners saturate
  // c, pixel (250,250) sits at c = -0.7 and never escapes within the default limit.
  task automatic test_reset_view();
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel('0, '1);
    send_pixel('1, '0);
    send_pixel(PIX_W'(250), PIX_W'(250));
    send_pixel(PIX_W'(100), PIX_W'(180));
    wait_results_idle();
  endtask

  // A zero limit runs no step: count 0, not escaped, black.
  // A limit of one, written with junk above bit 15, allows a single step.
  task automatic test_zero_limit();
    write_reg(REG_MAX_ITER, '0);
    send_pixel('0, '0);
    send_pixel(PIX_W'(250), PIX_W'(250));
    send_pixel('1, '1);
    wait_results_idle();
    write_reg(REG_MAX_ITER, {{(CFG_W - ITER_W){1'b1}}, ITER_W'(1)});
    send_pixel('0, '0);
    send_pixel(PIX_W'(250), PIX_W'(250));
    wait_results_idle();
  endtask

  // Register extremes: full and zero steps, both origin limits, then writes to
  // unused indexes, which must change nothing.
  task automatic test_register_extremes();
    logic signed [ORG_W-1:0] org_min;
    logic signed [ORG_W-1:0] org_max;
    org_min = {1'b1, {(ORG_W - 1){1'b0}}};
    org_max = -(org_min + 1);
    write_view(CFG_W'(64), '1, CFG_W'(org_min), '0, CFG_W'(org_max));
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel(PIX_W'(1), '0);
    wait_results_idle();
    write_view(CFG_W'(64), CFG_W'(1) << FRAC_BITS, CFG_W'(org_max),
               CFG_W'(1) << FRAC_BITS, CFG_W'(org_min));
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel(PIX_W'(2), PIX_W'(3));
    wait_results_idle();
    for (int i = int'(REG_C_ORIGIN_Y) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), '1);
    end
    send_pixel(PIX_W'(2), PIX_W'(3));
    wait_results_idle();
  endtask

  // Highest limit: c = 0 runs all 65535 steps, c = 0.3 escapes slowly,
  // c = -4 escapes on the first step. Drain before each register write.
  task automatic test_long_limit();
    write_view(CFG_W'({ITER_W{1'b1}}), '0, '0, '0, '0);
    send_pixel(PIX_W'(7), PIX_W'(9));
    wait_results_idle();
    write_reg(REG_C_ORIGIN_X, CFG_W'(80530637));
    send_pixel('0, '0);
    wait_results_idle();
    write_reg(REG_C_ORIGIN_X, CFG_W'(-(longint'(4) <<< FRAC_BITS)));
    send_pixel('1, '0);
    wait_results_idle();
  endtask

  // Random views under each sender gap density
  task automatic test_random_views();
    for (int ph = 0; ph < 3; ph++) begin
      req_gap_pct = IDLE_PCT[ph];
      for (int v = 0; v < VIEWS_PER_PHASE; v++) begin
        wait_results_idle();
        load_random_view();
        for (int k = 0; k < PIXELS_PER_VIEW; k++) begin
          send_pixel(pick_coord(view_w), pick_coord(view_h));
        end
      end
    end
    req_gap_pct = 0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_MAX_ITER;
    cfg_data        = '0;
    start           = 1'b0;
    pixel_x         = '0;
    pixel_y         = '0;
    view_iter_limit = ITER_W'(256);
    view_step_x     = STEP_W'(1610613);
    view_origin_x   = ORG_W'(-590558003);
    view_step_y     = STEP_W'(1610613);
    view_origin_y   = ORG_W'(-402653184);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_view();
    test_zero_limit();
    test_register_extremes();
    test_long_limit();
    test_random_views();

    // Drain, then give a stray late result time to show up
    wait_results_idle();
    repeat (int'(view_iter_limit) + 8) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mpe_pkg.sv
rtl/mpe_front.sv
rtl/mpe_queue.sv
rtl/mpe_iter.sv
rtl/mandelbrot_pixel_escape.sv
verif/mandelbrot_pixel_escape_tb.sv
